FILE: sv/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode, json_string_unescaper_top and the testbench; no dependencies.
package jsu_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_BAD_ESC   = 3'd2;
    localparam logic [2:0] ST_CUT_ESC   = 3'd3;
    localparam logic [2:0] ST_CUT_UNI   = 3'd4;
    localparam logic [2:0] ST_UNTERM    = 3'd5;

    // Decoder modes; 6 and 7 are never reached and decode as plain
    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX0    = 3'd2;
    localparam logic [2:0] MODE_HEX3    = 3'd5;

    // UTF-8 framing
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [15:0] UTF8_LIM1   = 16'h0080;
    localparam logic [15:0] UTF8_LIM2   = 16'h0800;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] res;      // res[0] goes out first
        logic [1:0]            count;    // number of results, 0..3
        logic [2:0]            mode_next;
        logic [15:0]           acc_next;
    } decode_t;

    // Hex digit value; anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

FILE: sv/jsu_decode.sv
// Combinational decode of one string byte against the current mode.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic [7:0]      in_byte,
    input  logic            text_ends,
    input  logic [2:0]      mode,
    input  logic [15:0]     acc,
    output jsu_pkg::decode_t dec
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [2:0]  mode_eff;
    logic [15:0] code;

    assign mode_eff = (mode > jsu_pkg::MODE_HEX3) ? jsu_pkg::MODE_PLAIN : mode;
    assign code     = {acc[11:0], jsu_pkg::hex_value(in_byte)};

    // Next mode, accumulator and result list
    always_comb begin
        dec           = '0;
        dec.mode_next = jsu_pkg::MODE_PLAIN;
        dec.acc_next  = '0;
        if (text_ends) begin
            dec.count = 2'd1;
            if (mode_eff == jsu_pkg::MODE_PLAIN) begin
                dec.res[0].status = jsu_pkg::ST_UNTERM;
            end else if (mode_eff == jsu_pkg::MODE_ESC) begin
                dec.res[0].status = jsu_pkg::ST_CUT_ESC;
            end else begin
                dec.res[0].status = jsu_pkg::ST_CUT_UNI;
            end
        end else if (mode_eff == jsu_pkg::MODE_PLAIN) begin
            dec.acc_next = acc;
            if (in_byte == CH_QUOTE) begin
                dec.count         = 2'd1;
                dec.res[0].status = jsu_pkg::ST_DONE;
                dec.acc_next      = '0;
            end else if (in_byte == CH_BSL) begin
                dec.mode_next = jsu_pkg::MODE_ESC;
            end else begin
                dec.count           = 2'd1;
                dec.res[0].out_byte = in_byte;
                dec.res[0].has_byte = 1'b1;
            end
        end else if (mode_eff == jsu_pkg::MODE_ESC) begin
            dec.count           = 2'd1;
            dec.res[0].has_byte = 1'b1;
            dec.acc_next        = acc;
            unique case (in_byte)
                CH_QUOTE: dec.res[0].out_byte = CH_QUOTE;
                CH_BSL:   dec.res[0].out_byte = CH_BSL;
                CH_SLASH: dec.res[0].out_byte = CH_SLASH;
                CH_N:     dec.res[0].out_byte = 8'h0A;
                CH_R:     dec.res[0].out_byte = 8'h0D;
                CH_T:     dec.res[0].out_byte = 8'h09;
                CH_B:     dec.res[0].out_byte = 8'h08;
                CH_F:     dec.res[0].out_byte = 8'h0C;
                CH_U: begin
                    dec.count           = 2'd0;
                    dec.res[0].has_byte = 1'b0;
                    dec.acc_next        = '0;
                    dec.mode_next       = jsu_pkg::MODE_HEX0;
                end
                default: begin
                    dec.res[0].has_byte = 1'b0;
                    dec.res[0].status   = jsu_pkg::ST_BAD_ESC;
                    dec.acc_next        = '0;
                end
            endcase
        end else if (mode_eff != jsu_pkg::MODE_HEX3) begin
            // first three hex digits: gather only
            dec.acc_next  = code;
            dec.mode_next = mode_eff + 3'd1;
        end else begin
            // fourth digit: emit UTF-8
            dec.res[0].has_byte = 1'b1;
            dec.res[1].has_byte = 1'b1;
            dec.res[2].has_byte = 1'b1;
            if (code < jsu_pkg::UTF8_LIM1) begin
                dec.count           = 2'd1;
                dec.res[0].out_byte = code[7:0];
            end else if (code < jsu_pkg::UTF8_LIM2) begin
                dec.count           = 2'd2;
                dec.res[0].out_byte = jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
                dec.res[1].out_byte = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
            end else begin
                dec.count           = 2'd3;
                dec.res[0].out_byte = jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
                dec.res[1].out_byte = jsu_pkg::UTF8_CONT | {2'b00, code[11:6]};
                dec.res[2].out_byte = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
            end
        end
    end

endmodule

FILE: sv/json_string_unescaper_top.sv
// JSON string unescaper: one string byte in, zero to three decoded bytes out.
// The first result is registered and valid in the cycle after the request is accepted.
// Throughput: one byte per cycle while the receiver takes results; a \u escape giving
// 2 or 3 UTF-8 bytes holds the input while the result queue drains.
// Reset (aresetn low, synchronous) empties the queue, returns to plain mode.
// Depends on jsu_pkg and jsu_decode.
module json_string_unescaper_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] text_ends
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [0] has_byte, [3:1] status
    output logic       m_tlast
);

    logic [2:0]                                 mode_reg, mode_next;
    logic [15:0]                                acc_reg, acc_next;
    jsu_pkg::result_t [jsu_pkg::MAX_RES-1:0]    res_reg, res_next;
    logic [1:0]                                 cnt_reg, cnt_next;
    jsu_pkg::decode_t                           dec;
    logic                                       push, pop;

    jsu_decode u_decode (
        .in_byte   (s_tdata),
        .text_ends (s_tuser),
        .mode      (mode_reg),
        .acc       (acc_reg),
        .dec       (dec)
    );

    // Handshakes: take a new request once the queue is empty or its last result leaves in this cycle
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign push     = s_tvalid && s_tready;

    // Queue and decoder state update
    always_comb begin
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        if (push) begin
            res_next  = dec.res;
            cnt_next  = dec.count;
            mode_next = dec.mode_next;
            acc_next  = dec.acc_next;
        end else if (pop) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            mode_reg <= jsu_pkg::MODE_PLAIN;
            acc_reg  <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Head of the queue drives the result channel
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = res_reg[0].out_byte;
    assign m_tuser  = {res_reg[0].status, res_reg[0].has_byte};
    assign m_tlast  = (cnt_reg == 2'd1);

    // A request is only taken when the queue is empty or empties in this cycle
    a_push_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("request accepted over pending results");

    // A request that yields nothing leaves the result channel idle
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && dec.count == 2'd0) |=> !m_tvalid)
        else $error("phantom result");

    // Status results carry no byte and close their request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3:1] != jsu_pkg::ST_OK) |-> (!m_tuser[0] && m_tlast))
        else $error("status result malformed");

    // Mode never leaves the defined range
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg <= jsu_pkg::MODE_HEX3)
        else $error("decoder mode out of range");

endmodule

FILE: dv/testbench.sv
// Testbench for json_string_unescaper_top: directed table, then random string traffic.
// Every result is compared against an in-bench decoder model, field by field.
// Depends on jsu_pkg and the RTL of json_string_unescaper_top.
module testbench;

    // Characters with a special meaning in a string body
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // One decoded byte as it should leave the block
    typedef struct {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] status;
        logic       last;
    } decoded_t;

    // One row of the directed table; typed rows carry their single result
    typedef struct {
        logic [7:0] in_byte;
        logic       text_ends;
        bit         typed;
        logic [7:0] t_byte;
        logic       t_has;
        logic [2:0] t_status;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    // Decoder model state
    logic [2:0]  dec_mode = jsu_pkg::MODE_PLAIN;
    logic [15:0] dec_acc = 16'h0000;
    decoded_t    decoded_q[$];

    int tx_idle = 0;
    int rx_stall = 0;
    int hold_start = 0;
    int err_cnt = 0;

    json_string_unescaper_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp);
        $display("mismatch %s: got %0h, expected %0h", what, got, exp);
        err_cnt++;
    endtask

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    // Model of one request: updates mode/accumulator, queues 0..3 decoded bytes
    function automatic void unescape_byte(input logic [7:0] c, input logic ends);
        decoded_t    res[3];
        int          n;
        logic [2:0]  m;
        logic [15:0] code;
        logic [7:0]  b;
        n = 0;
        m = dec_mode;
        if (m > jsu_pkg::MODE_HEX3) m = jsu_pkg::MODE_PLAIN;
        for (int i = 0; i < 3; i++) res[i] = '{8'h00, 1'b0, jsu_pkg::ST_OK, 1'b0};
        if (ends) begin
            res[n].status = (m == jsu_pkg::MODE_PLAIN) ? jsu_pkg::ST_UNTERM :
                            (m == jsu_pkg::MODE_ESC) ? jsu_pkg::ST_CUT_ESC :
                            jsu_pkg::ST_CUT_UNI;
            n++;
            dec_mode = jsu_pkg::MODE_PLAIN;
            dec_acc = 16'h0000;
        end else if (m == jsu_pkg::MODE_PLAIN) begin
            if (c == CH_QUOTE) begin
                res[n].status = jsu_pkg::ST_DONE;
                n++;
                dec_mode = jsu_pkg::MODE_PLAIN;
                dec_acc = 16'h0000;
            end else if (c == CH_BSLASH) begin
                dec_mode = jsu_pkg::MODE_ESC;
            end else begin
                res[n] = '{c, 1'b1, jsu_pkg::ST_OK, 1'b0};
                n++;
                dec_mode = jsu_pkg::MODE_PLAIN;
            end
        end else if (m == jsu_pkg::MODE_ESC) begin
            if (c == CH_U) begin
                dec_acc = 16'h0000;
                dec_mode = jsu_pkg::MODE_HEX0;
            end else begin
                b = 8'h00;
                case (c)
                    8'h22: b = 8'h22;
                    8'h5C: b = 8'h5C;
                    8'h2F: b = 8'h2F;
                    8'h6E: b = 8'h0A;
                    8'h72: b = 8'h0D;
                    8'h74: b = 8'h09;
                    8'h62: b = 8'h08;
                    8'h66: b = 8'h0C;
                    default: b = 8'h00;
                endcase
                if (b == 8'h00) begin
                    res[n].status = jsu_pkg::ST_BAD_ESC;
                    n++;
                    dec_acc = 16'h0000;
                end else begin
                    res[n] = '{b, 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                end
                dec_mode = jsu_pkg::MODE_PLAIN;
            end
        end else begin
            code = {dec_acc[11:0], nibble_of(c)};
            if (m < jsu_pkg::MODE_HEX3) begin
                dec_acc = code;
                dec_mode = m + 3'd1;
            end else begin
                // UTF-8 encode, one to three bytes
                if (code < 16'h0080) begin
                    res[n] = '{code[7:0], 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                end else if (code < 16'h0800) begin
                    res[n] = '{8'hC0 | 8'(code >> 6), 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                    res[n] = '{8'h80 | {2'b00, code[5:0]}, 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                end else begin
                    res[n] = '{8'hE0 | 8'(code >> 12), 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                    res[n] = '{8'h80 | {2'b00, code[11:6]}, 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                    res[n] = '{8'h80 | {2'b00, code[5:0]}, 1'b1, jsu_pkg::ST_OK, 1'b0};
                    n++;
                end
                dec_mode = jsu_pkg::MODE_PLAIN;
                dec_acc = 16'h0000;
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) decoded_q = {decoded_q, res[i]};
    endfunction

    // Offer one request, with random sender idle cycles ahead of it
    task automatic offer(input logic [7:0] b, input logic ends);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= ends;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unescape_byte(b, ends);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) c = 8'h30 + 8'(v);
        else c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = CH_QUOTE;
            1: c = CH_BSLASH;
            2: c = 8'h67;
            default: c = 8'($urandom_range(8'h80, 8'hFF));
        endcase
        return c;
    endfunction

    // One random piece of string text; returns the number of requests sent
    task automatic send_segment(output int cnt);
        logic [7:0]  esc_letters[8];
        logic [15:0] code;
        int          k;
        int          pick;
        esc_letters = '{8'h22, 8'h5C, 8'h2F, 8'h6E, 8'h72, 8'h74, 8'h62, 8'h66};
        cnt = 0;
        pick = $urandom_range(99);
        if (pick < 35) begin
            offer(8'($urandom_range(255)), 1'b0);
            cnt = 1;
        end else if (pick < 55) begin
            offer(CH_BSLASH, 1'b0);
            offer(esc_letters[$urandom_range(7)], 1'b0);
            cnt = 2;
        end else if (pick < 80) begin
            case ($urandom_range(2))
                0: code = 16'($urandom_range(16'h0000, 16'h007F));
                1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            offer(CH_BSLASH, 1'b0);
            offer(CH_U, 1'b0);
            for (int i = 3; i >= 0; i--) begin
                if ($urandom_range(7) == 0) offer(non_hex_char(), 1'b0);
                else offer(hex_char(code[i*4 +: 4]), 1'b0);
            end
            cnt = 6;
        end else if (pick < 88) begin
            offer(CH_QUOTE, 1'b0);
            cnt = 1;
        end else if (pick < 93) begin
            offer(8'($urandom_range(255)), 1'b1);
            cnt = 1;
        end else begin
            // broken escapes: odd letter, or text cut short
            offer(CH_BSLASH, 1'b0);
            cnt = 1;
            case ($urandom_range(2))
                0: begin
                    offer(8'($urandom_range(255)), 1'b0);
                    cnt++;
                end
                1: begin
                    offer(8'($urandom_range(255)), 1'b1);
                    cnt++;
                end
                default: begin
                    offer(CH_U, 1'b0);
                    k = $urandom_range(3);
                    for (int i = 0; i < k; i++) offer(hex_char(4'($urandom_range(15))), 1'b0);
                    offer(8'($urandom_range(255)), 1'b1);
                    cnt += k + 2;
                end
            endcase
        end
    endtask

    function automatic stim_row_t row_p(input logic [7:0] b, input logic ends);
        stim_row_t r;
        r = '{b, ends, 1'b0, 8'h00, 1'b0, jsu_pkg::ST_OK};
        return r;
    endfunction

    function automatic stim_row_t row_t(input logic [7:0] b, input logic ends,
                                        input logic [7:0] tb, input logic th,
                                        input logic [2:0] ts);
        stim_row_t r;
        r = '{b, ends, 1'b1, tb, th, ts};
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off when the sender asks
    initial begin : rx_side
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_start > 0) begin
                hold_cnt = hold_start;
                hold_start = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        decoded_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result", {8'h00, m_tdata}, 16'h0000);
            end else begin
                e = decoded_q.pop_front();
                if (m_tdata !== e.out_byte)
                    report_mismatch("out_byte", {8'h00, m_tdata}, {8'h00, e.out_byte});
                if (m_tuser[0] !== e.has_byte)
                    report_mismatch("has_byte", {15'h0, m_tuser[0]}, {15'h0, e.has_byte});
                if (m_tuser[3:1] !== e.status)
                    report_mismatch("status", {13'h0, m_tuser[3:1]}, {13'h0, e.status});
                if (m_tlast !== e.last)
                    report_mismatch("last", {15'h0, m_tlast}, {15'h0, e.last});
            end
        end
    end

    // Stimulus
    initial begin : tx_side
        stim_row_t dir_rows[$];
        decoded_t  t;
        int        sent;
        int        n;
        int        idle_tx[4];
        int        idle_rx[4];
        idle_tx = '{0, 78, 0, 13};
        idle_rx = '{0, 0, 78, 13};
        dir_rows = '{
            row_t(8'hA5, 1'b1, 8'h00, 1'b0, jsu_pkg::ST_UNTERM),    // end of text at once
            row_t(8'h00, 1'b0, 8'h00, 1'b1, jsu_pkg::ST_OK),
            row_t(8'hFF, 1'b0, 8'hFF, 1'b1, jsu_pkg::ST_OK),
            row_t(CH_QUOTE, 1'b0, 8'h00, 1'b0, jsu_pkg::ST_DONE),
            row_p(CH_BSLASH, 1'b0),                        // bad escape letter
            row_t(8'h71, 1'b0, 8'h00, 1'b0, jsu_pkg::ST_BAD_ESC),
            row_p(CH_BSLASH, 1'b0),                        // cut after backslash
            row_t(8'h00, 1'b1, 8'h00, 1'b0, jsu_pkg::ST_CUT_ESC),
            row_p(CH_BSLASH, 1'b0),                        // two-byte UTF-8
            row_p(CH_U, 1'b0),
            row_p(8'h30, 1'b0),
            row_p(8'h37, 1'b0),
            row_p(8'h46, 1'b0),
            row_p(8'h66, 1'b0),
            row_p(CH_BSLASH, 1'b0),                        // quote, backslash as digits
            row_p(CH_U, 1'b0),
            row_p(8'h45, 1'b0),
            row_p(CH_QUOTE, 1'b0),
            row_p(CH_BSLASH, 1'b0),
            row_p(8'h61, 1'b0),
            row_p(CH_BSLASH, 1'b0),                        // cut inside hex digits
            row_p(CH_U, 1'b0),
            row_p(8'h39, 1'b0),
            row_t(CH_BSLASH, 1'b1, 8'h00, 1'b0, jsu_pkg::ST_CUT_UNI)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (dir_rows[i]) begin
            offer(dir_rows[i].in_byte, dir_rows[i].text_ends);
            if (dir_rows[i].typed) begin
                t = decoded_q[$];
                if (t.out_byte !== dir_rows[i].t_byte || t.has_byte !== dir_rows[i].t_has ||
                    t.status !== dir_rows[i].t_status)
                    report_mismatch("table row", 16'(i), {13'h0, dir_rows[i].t_status});
            end
        end

        // Random traffic in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            // sender pauses until everything has drained
            s_tvalid <= 1'b0;
            while (decoded_q.size() != 0) @(posedge aclk);
            tx_idle = idle_tx[ph];
            rx_stall = idle_rx[ph];
            if (ph == 0) hold_start = 80;
            sent = 0;
            while (sent < 96) begin
                send_segment(n);
                sent += n;
            end
        end
        s_tvalid <= 1'b0;
        rx_stall = 0;

        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (decoded_q.size() != 0)
            report_mismatch("leftover results", 16'(decoded_q.size()), 16'h0000);
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: json_string_unescaper_top.f
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/json_string_unescaper_top.sv
dv/testbench.sv
